>>> hdl/psched_pkg.sv
// Shared types, codes and sizes for the process scheduler select block.
`default_nettype none

package psched_pkg;

   localparam int SLOTS  = 8;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int KEY_W  = 25;

   localparam logic FUNC_LOAD     = 1'b0;
   localparam logic FUNC_DISPATCH = 1'b1;

   localparam logic [1:0] POL_FIFO = 2'd0;
   localparam logic [1:0] POL_SJF  = 2'd1;
   localparam logic [1:0] POL_HPF  = 2'd2;
   localparam logic [1:0] POL_RR   = 2'd3;

   localparam logic [1:0] STAT_DISPATCHED = 2'd0;
   localparam logic [1:0] STAT_LOADED     = 2'd1;
   localparam logic [1:0] STAT_EMPTY      = 2'd2;

   localparam logic CSR_POLICY  = 1'b0;
   localparam logic CSR_QUANTUM = 1'b1;

   localparam logic [15:0] QUANTUM_RESET = 16'd3;

   typedef struct packed {
      logic        func;
      logic [2:0]  slot;
      logic [7:0]  proc_id;
      logic [15:0] burst_time;
      logic [7:0]  prio;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  chosen_slot;
      logic [7:0]  chosen_id;
      logic [15:0] granted_time;
      logic        finished;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_GRANT
   } state_type;

endpackage

`default_nettype wire

>>> hdl/process_scheduler_select.sv
// Process scheduler select: slot table, scan sequencer and config registers.
// A load request gives its response in the cycle after acceptance; one request per cycle
// while the output register is free. A dispatch scans all slots, one per cycle, through a
// shared key compare, then responds from the grant state; new requests wait until idle.
// The grant cycle holds while the output register is still full.
// Synchronous reset clears live marks, round-robin state, policy (fifo) and quantum (3).
`default_nettype none

module process_scheduler_select
   import psched_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output rsp_type      rsp_data,
   input  wire          psel,
   input  wire          penable,
   input  wire          pwrite,
   input  wire  [2:0]   paddr,
   input  wire  [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   // slot table
   logic [7:0]       slot_id_ff    [SLOTS];
   logic [15:0]      slot_burst_ff [SLOTS];
   logic [7:0]       slot_prio_ff  [SLOTS];
   logic [SLOTS-1:0] live_ff, live_in;

   logic [1:0]  policy_ff, policy_in;
   logic [15:0] quantum_ff, quantum_in;
   logic [7:0]  last_id_ff, last_id_in;
   logic        have_last_ff, have_last_in;

   state_type   state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic        found_ff, found_in;
   logic [KEY_W-1:0]  best_key_ff, best_key_in;
   logic [SLOT_W-1:0] best_slot_ff, best_slot_in;
   logic [7:0]  best_id_ff, best_id_in;
   logic [15:0] best_burst_ff, best_burst_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // table write port
   logic              tab_load;
   logic              tab_grant;
   logic [SLOT_W-1:0] load_idx;
   logic [15:0]       burst_wr_in;

   logic [7:0]        cur_id;
   logic [15:0]       cur_burst;
   logic [7:0]        cur_prio;
   logic              cur_wrap;
   logic [KEY_W-1:0]  cur_key;
   logic              take;
   logic              out_free;
   logic              req_acc;
   logic [15:0]       eff_quantum;
   logic              cfg_wr;

   assign pready    = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_acc   = req_valid && req_ready;
   assign load_idx  = SLOT_W'(req_data.slot);
   assign cfg_wr    = psel && penable && pwrite && pready;

   always_comb begin
      unique case (paddr[2])
         CSR_POLICY:  prdata = {30'd0, policy_ff};
         CSR_QUANTUM: prdata = {16'd0, quantum_ff};
         default:     prdata = 32'd0;
      endcase
   end

   // shared compare unit: key of the slot under the scan pointer
   always_comb begin
      cur_id    = slot_id_ff[idx_ff];
      cur_burst = slot_burst_ff[idx_ff];
      cur_prio  = slot_prio_ff[idx_ff];
      // ids at or below the last one served sort after all others
      cur_wrap  = !(have_last_ff && (cur_id > last_id_ff));
      unique case (policy_ff)
         POL_SJF: cur_key = {1'b0, cur_burst, cur_id};
         POL_HPF: cur_key = {1'b0, 8'd0, cur_prio, cur_id};
         POL_RR:  cur_key = {cur_wrap, 16'd0, cur_id};
         default: cur_key = {1'b0, 16'd0, cur_id};
      endcase
      take = live_ff[idx_ff] && (!found_ff || (cur_key < best_key_ff));
   end

   assign eff_quantum = (quantum_ff == 16'd0) ? 16'd1 : quantum_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      best_key_in   = best_key_ff;
      best_slot_in  = best_slot_ff;
      best_id_in    = best_id_ff;
      best_burst_in = best_burst_ff;
      live_in       = live_ff;
      last_id_in    = last_id_ff;
      have_last_in  = have_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      tab_load      = 1'b0;
      tab_grant     = 1'b0;
      burst_wr_in   = best_burst_ff;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (req_acc) begin
               if (req_data.func == FUNC_LOAD) begin
                  // drop writes to slots beyond the table
                  if (int'(req_data.slot) < SLOTS) begin
                     tab_load          = 1'b1;
                     live_in[load_idx] = (req_data.burst_time != 16'd0);
                  end
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_data_in.status = STAT_LOADED;
               end else begin
                  idx_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (take) begin
               found_in      = 1'b1;
               best_key_in   = cur_key;
               best_slot_in  = idx_ff;
               best_id_in    = cur_id;
               best_burst_in = cur_burst;
            end
            if (idx_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = ST_GRANT;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_GRANT: begin
            // hold until the output register can take the response
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
               if (!found_ff) begin
                  rsp_data_in.status = STAT_EMPTY;
               end else begin
                  tab_grant = 1'b1;
                  rsp_data_in.status      = STAT_DISPATCHED;
                  rsp_data_in.chosen_slot = 3'(best_slot_ff);
                  rsp_data_in.chosen_id   = best_id_ff;
                  if ((policy_ff == POL_RR) && (eff_quantum < best_burst_ff)) begin
                     burst_wr_in              = best_burst_ff - eff_quantum;
                     rsp_data_in.granted_time = eff_quantum;
                     rsp_data_in.finished     = 1'b0;
                  end else begin
                     burst_wr_in              = 16'd0;
                     live_in[best_slot_ff]    = 1'b0;
                     rsp_data_in.granted_time = best_burst_ff;
                     rsp_data_in.finished     = 1'b1;
                  end
                  if (policy_ff == POL_RR) begin
                     last_id_in   = best_id_ff;
                     have_last_in = 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      policy_in  = policy_ff;
      quantum_in = quantum_ff;
      if (cfg_wr) begin
         unique case (paddr[2])
            CSR_POLICY:  policy_in  = pwdata[1:0];
            CSR_QUANTUM: quantum_in = pwdata[15:0];
            default:     policy_in  = policy_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         last_id_ff   <= 8'd0;
         have_last_ff <= 1'b0;
         policy_ff    <= POL_FIFO;
         quantum_ff   <= QUANTUM_RESET;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         last_id_ff   <= last_id_in;
         have_last_ff <= have_last_in;
         policy_ff    <= policy_in;
         quantum_ff   <= quantum_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      best_key_ff   <= best_key_in;
      best_slot_ff  <= best_slot_in;
      best_id_ff    <= best_id_in;
      best_burst_ff <= best_burst_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (tab_load) begin
         slot_id_ff[load_idx]    <= req_data.proc_id;
         slot_burst_ff[load_idx] <= req_data.burst_time;
         slot_prio_ff[load_idx]  <= req_data.prio;
      end else if (tab_grant) begin
         slot_burst_ff[best_slot_ff] <= burst_wr_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/psched_checker.sv
// Port-level checker for the process scheduler select block, with its bind.
`default_nettype none

module psched_checker
   import psched_pkg::*;
(
   input wire          clock,
   input wire          reset,
   input wire          req_valid,
   input wire          req_ready,
   input wire req_type req_data,
   input wire          rsp_valid,
   input wire          rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_load_reply: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.func == FUNC_LOAD)
      |=> rsp_valid && (rsp_data.status == STAT_LOADED))
      else $error("load request without a loaded response");

   a_dispatch_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.func == FUNC_DISPATCH) |=> !req_ready)
      else $error("request taken during a dispatch scan");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STAT_DISPATCHED)
      |-> (rsp_data.chosen_id == 8'd0) && (rsp_data.granted_time == 16'd0)
          && (rsp_data.finished == 1'b0) && (rsp_data.chosen_slot == 3'd0))
      else $error("non-dispatch response carries grant fields");

   a_grant_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STAT_DISPATCHED) |-> rsp_data.granted_time != 16'd0)
      else $error("dispatch granted no time");

endmodule

bind process_scheduler_select psched_checker u_psched_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
